// ----- rtl/rtle_pkg.sv -----
// ----------------------------------------------------------------------------
// rtle_pkg
// Shared types and constants of the recorded text line editor.
// ----------------------------------------------------------------------------
`default_nettype none

package rtle_pkg;

  localparam int CHAR_W            = 7;
  localparam int CNT_W             = 8;
  localparam int IDX_W             = 8;
  localparam int BS_W              = 2;
  localparam int DATA_W            = 8;
  localparam int DEFAULT_MAX_CHARS = 255;

  localparam logic [CHAR_W-1:0] SPACE_CODE = 7'd32;

  typedef enum logic [2:0] {
    KIND_START = 3'd0,
    KIND_CHAR  = 3'd1,
    KIND_CORR  = 3'd2,
    KIND_STOP  = 3'd3,
    KIND_READ  = 3'd4
  } kind_e;

  typedef struct packed {
    logic load;
    logic rd;
    logic exec;
  } rtle_cmd_t;

endpackage : rtle_pkg

`default_nettype wire

// ----- rtl/rtle_ram.sv -----
// ----------------------------------------------------------------------------
// rtle_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rtle_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : rtle_ram

`default_nettype wire

// ----- rtl/rtle_ctrl.sv -----
// ----------------------------------------------------------------------------
// rtle_ctrl
// Controller of the line editor: sequences load, store read and execute.
// ----------------------------------------------------------------------------
`default_nettype none

module rtle_ctrl
  import rtle_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  output logic      busy_o,
  output logic      valid_o,
  output rtle_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   valid_q, valid_d;

  always_comb begin
    state_d = state_q;
    valid_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        valid_d = 1'b1;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  assign busy_o     = (state_q != ST_IDLE);
  assign valid_o    = valid_q;
  assign cmd_o.load = start_i && (state_q == ST_IDLE);
  assign cmd_o.rd   = (state_q == ST_RD);
  assign cmd_o.exec = (state_q == ST_EXEC);

endmodule : rtle_ctrl

`default_nettype wire

// ----- rtl/rtle_dp.sv -----
// ----------------------------------------------------------------------------
// rtle_dp
// Datapath of the line editor: transaction registers, character store,
// length and recording state, and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module rtle_dp
  import rtle_pkg::*;
#(
  parameter int MaxChars = DEFAULT_MAX_CHARS
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rtle_cmd_t         cmd_i,
  input  wire logic [2:0]        kind_i,
  input  wire logic [CHAR_W-1:0] char_code_i,
  input  wire logic [IDX_W-1:0]  read_index_i,
  output logic                   accepted_o,
  output logic [CNT_W-1:0]       text_length_o,
  output logic [BS_W-1:0]        backspaces_o,
  output logic [DATA_W-1:0]      read_data_o,
  output logic                   recording_o
);

  localparam int AddrW = (MaxChars > 1) ? $clog2(MaxChars) : 1;
  localparam logic [CNT_W-1:0] Capacity = CNT_W'(MaxChars);

  logic [2:0]        kind_q;
  logic [CHAR_W-1:0] char_q;
  logic [IDX_W-1:0]  idx_q;

  logic [CNT_W-1:0]  count_q, count_d;
  logic              armed_q, armed_d;

  logic              acc_q, acc_d;
  logic [BS_W-1:0]   bs_q, bs_d;
  logic [DATA_W-1:0] rd_q, rd_d;

  logic              we;
  logic [CNT_W-1:0]  rd_pos;
  logic [CHAR_W-1:0] rdata;

  always_comb begin
    if (kind_q == KIND_READ) begin
      rd_pos = CNT_W'(idx_q - IDX_W'(1));
    end else begin
      rd_pos = count_q - CNT_W'(1);
    end
  end

  rtle_ram #(
    .Width (CHAR_W),
    .Depth (MaxChars),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (char_q),
    .re_i    (cmd_i.rd),
    .raddr_i (rd_pos[AddrW-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    count_d = count_q;
    armed_d = armed_q;
    acc_d   = 1'b0;
    bs_d    = '0;
    rd_d    = '0;
    we      = 1'b0;
    case (kind_q)
      KIND_START: begin
        count_d = '0;
        armed_d = 1'b1;
      end
      KIND_CHAR: begin
        if (!armed_q) begin
          acc_d = 1'b1;
        end else if (count_q >= Capacity) begin
          acc_d = 1'b0;
        end else if ((char_q == SPACE_CODE) &&
                     ((count_q == '0) || (rdata == SPACE_CODE))) begin
          acc_d = 1'b0;
        end else begin
          acc_d   = 1'b1;
          we      = cmd_i.exec;
          count_d = count_q + CNT_W'(1);
        end
      end
      KIND_CORR: begin
        // Spaces never follow one another, so at most one trailing space.
        if (armed_q && (count_q != '0)) begin
          if ((rdata == SPACE_CODE) && (count_q > CNT_W'(1))) begin
            count_d = count_q - CNT_W'(2);
            bs_d    = BS_W'(2);
          end else begin
            count_d = count_q - CNT_W'(1);
            bs_d    = BS_W'(1);
          end
        end
      end
      KIND_STOP: begin
        armed_d = 1'b0;
      end
      KIND_READ: begin
        if (idx_q == '0) begin
          rd_d = DATA_W'(count_q);
        end else if (CNT_W'(idx_q) <= count_q) begin
          rd_d = DATA_W'(rdata);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      char_q <= char_code_i;
      idx_q  <= read_index_i;
    end
    if (cmd_i.exec) begin
      acc_q <= acc_d;
      bs_q  <= bs_d;
      rd_q  <= rd_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      armed_q <= 1'b0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
      armed_q <= armed_d;
    end
  end

  assign accepted_o    = acc_q;
  assign text_length_o = count_q;
  assign backspaces_o  = bs_q;
  assign read_data_o   = rd_q;
  assign recording_o   = armed_q;

endmodule : rtle_dp

`default_nettype wire

// ----- rtl/recorded_text_line_editor_top.sv -----
// ----------------------------------------------------------------------------
// recorded_text_line_editor_top
// Recorded text line editor: stores a short text message of up to MaxChars
// characters and handles start, character, correction, stop and read
// transactions.
//
// A transaction is accepted at a rising edge with start high and busy low.
// kind_i selects the operation; char_code_i is used by character
// transactions and read_index_i by read transactions.
// Every transaction gives one result, shown for exactly one cycle while
// result_valid_o is high. The receiver cannot hold it off.
// The store is read in state ST_RD after acceptance, state and result
// registers update at the end of ST_EXEC, and the result strobe is high
// while the controller is back in ST_IDLE; the result is taken at the
// closing edge of that cycle. busy is high in ST_RD and ST_EXEC, so a new
// transaction can be accepted in the cycle that shows the previous result.
// The registered store read ahead of the update adds the ST_RD state.
// Reset clears the length and the recording flag; the character store is
// not cleared and holds nothing valid until written.
// ----------------------------------------------------------------------------
`default_nettype none

module recorded_text_line_editor_top
  import rtle_pkg::*;
#(
  parameter int MaxChars = DEFAULT_MAX_CHARS
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [2:0]        kind_i,
  input  wire logic [CHAR_W-1:0] char_code_i,
  input  wire logic [IDX_W-1:0]  read_index_i,
  output logic                   result_valid_o,
  output logic                   accepted_o,
  output logic [CNT_W-1:0]       text_length_o,
  output logic [BS_W-1:0]        backspaces_o,
  output logic [DATA_W-1:0]      read_data_o,
  output logic                   recording_o
);

  rtle_cmd_t cmd;

  rtle_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .valid_o (result_valid_o),
    .cmd_o   (cmd)
  );

  rtle_dp #(
    .MaxChars (MaxChars)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .kind_i        (kind_i),
    .char_code_i   (char_code_i),
    .read_index_i  (read_index_i),
    .accepted_o    (accepted_o),
    .text_length_o (text_length_o),
    .backspaces_o  (backspaces_o),
    .read_data_o   (read_data_o),
    .recording_o   (recording_o)
  );

  // The stored length never exceeds the capacity.
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    text_length_o <= CNT_W'(MaxChars))
    else $error("text length exceeds capacity");

  // An accepted transaction always produces a result strobe.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##3 result_valid_o)
    else $error("result strobe missing");

  // A correction never removes more than two characters.
  a_bs_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (backspaces_o != BS_W'(3)))
    else $error("too many backspaces");

  // The length changes only when a result is delivered.
  a_len_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !result_valid_o |-> $stable(text_length_o) || $past(!rst_ni))
    else $error("length changed without a result");

endmodule : recorded_text_line_editor_top

`default_nettype wire
